// ===== design/vlsp_pkg.sv =====
package vlsp_pkg;

	localparam int unsigned TIMER_BITS_DEF = 16;
	localparam int unsigned CFG_INDEX_W    = 8;
	localparam int unsigned CFG_DATA_W     = 16;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HUNT_TIMEOUT  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_READY_TIMEOUT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PING_PERIOD   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STATUS_CODE   = 8'd3;

	localparam logic [15:0] HUNT_TIMEOUT_RST  = 16'd250;
	localparam logic [15:0] READY_TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] PING_PERIOD_RST   = 16'd1000;
	localparam logic [7:0]  STATUS_CODE_RST   = 8'd113;

	localparam logic [7:0] CODE_ESC  = 8'h1B;
	localparam logic [7:0] CODE_SEP  = 8'h13;
	localparam logic [7:0] CODE_PRO1 = 8'h39;
	localparam logic [7:0] CODE_PRO2 = 8'h3A;
	localparam logic [7:0] CODE_PRO3 = 8'h3B;

	localparam logic [1:0] SPEED_300  = 2'd0;
	localparam logic [1:0] SPEED_1200 = 2'd1;
	localparam logic [1:0] SPEED_4800 = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_CHAR  = 3'd1;
	localparam logic [2:0] EV_ESC   = 3'd2;
	localparam logic [2:0] EV_SEP   = 3'd3;
	localparam logic [2:0] EV_PRO1  = 3'd4;
	localparam logic [2:0] EV_PRO2  = 3'd5;
	localparam logic [2:0] EV_PRO3  = 3'd6;

	// parser phases
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ESC  = 4'd1;
	localparam logic [3:0] PH_P1A  = 4'd2;
	localparam logic [3:0] PH_P2A  = 4'd3;
	localparam logic [3:0] PH_P2B  = 4'd4;
	localparam logic [3:0] PH_P3A  = 4'd5;
	localparam logic [3:0] PH_P3B  = 4'd6;
	localparam logic [3:0] PH_P3C  = 4'd7;
	localparam logic [3:0] PH_SEP  = 4'd8;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] code_first;
		logic [7:0] code_second;
		logic [7:0] code_third;
		logic       send_status_request;
		logic       send_speed_switch;
		logic [1:0] baud_select;
		logic       link_ready;
		logic       link_restarted;
	} result_t;

endpackage

// ===== design/vlsp_ifs.sv =====
interface vlsp_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] byte_value;

	modport source (output valid, output operation, output byte_value, input ready);
	modport sink (input valid, input operation, input byte_value, output ready);
endinterface

interface vlsp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] code_first;
	logic [7:0] code_second;
	logic [7:0] code_third;
	logic       send_status_request;
	logic       send_speed_switch;
	logic [1:0] baud_select;
	logic       link_ready;
	logic       link_restarted;

	modport source (output valid, output event_kind, output code_first, output code_second,
		output code_third, output send_status_request, output send_speed_switch,
		output baud_select, output link_ready, output link_restarted, input ready);
	modport sink (input valid, input event_kind, input code_first, input code_second,
		input code_third, input send_status_request, input send_speed_switch,
		input baud_select, input link_ready, input link_restarted, output ready);
endinterface

// ===== design/videotex_link_supervisor_parser_unit.sv =====
// An accepted input word enters the input register; its result is then computed and
// held in the result register until taken (the result register waits on out_ch.ready).
// Throughput: one word per cycle while out_ch.ready takes each result; parser and
// supervisor state update as a word passes from the input to the result register.
// Reset (arst_n low, asynchronous): parser idle, link down at 1200 baud, reply
// awaited, elapsed counter zero, configuration registers at their default values.
module videotex_link_supervisor_parser_unit #(
	parameter int unsigned TIMER_BITS = vlsp_pkg::TIMER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vlsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [vlsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	vlsp_in_if.sink                              in_ch,
	vlsp_out_if.source                           out_ch
);

	localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	// configuration
	logic [15:0] hunt_to_q, ready_to_q, ping_per_q;
	logic [7:0]  status_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_to_q     <= vlsp_pkg::HUNT_TIMEOUT_RST;
			ready_to_q    <= vlsp_pkg::READY_TIMEOUT_RST;
			ping_per_q    <= vlsp_pkg::PING_PERIOD_RST;
			status_code_q <= vlsp_pkg::STATUS_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vlsp_pkg::REG_HUNT_TIMEOUT:  hunt_to_q     <= cfg_data;
				vlsp_pkg::REG_READY_TIMEOUT: ready_to_q    <= cfg_data;
				vlsp_pkg::REG_PING_PERIOD:   ping_per_q    <= cfg_data;
				vlsp_pkg::REG_STATUS_CODE:   status_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			op_s1   <= in_ch.operation;
			byte_s1 <= in_ch.byte_value;
		end
	end

	// state
	logic [3:0]            phase_q, phase_n;
	logic [7:0]            held1_q, held1_n, held2_q, held2_n;
	logic                  ready_q, ready_n;
	logic [1:0]            speed_q, speed_n;
	logic [TIMER_BITS-1:0] since_q, since_n, since_t;
	logic                  await_q, await_n;
	vlsp_pkg::result_t     res, res_q;
	logic                  pong;

	always_comb begin
		phase_n = phase_q;
		held1_n = held1_q;
		held2_n = held2_q;
		ready_n = ready_q;
		speed_n = speed_q;
		await_n = await_q;
		since_t = since_q;
		pong    = 1'b0;
		res     = '0;

		if (op_s1 == vlsp_pkg::OP_TICK) begin
			since_t = (since_q == {TIMER_BITS{1'b1}}) ? since_q : since_q + 1'b1;
			if (phase_q == vlsp_pkg::PH_IDLE) begin
				if (!ready_q) begin
					if (!await_q || CMP_W'(since_t) > CMP_W'(hunt_to_q)) begin
						case (speed_q)
							vlsp_pkg::SPEED_1200: speed_n = vlsp_pkg::SPEED_4800;
							vlsp_pkg::SPEED_4800: speed_n = vlsp_pkg::SPEED_300;
							default:              speed_n = vlsp_pkg::SPEED_1200;
						endcase
						res.send_status_request = 1'b1;
					end
				end else if (await_q) begin
					if (CMP_W'(since_t) > CMP_W'(ready_to_q)) begin
						ready_n                 = 1'b0;
						speed_n                 = vlsp_pkg::SPEED_1200;
						res.link_restarted      = 1'b1;
						res.send_status_request = 1'b1;
					end
				end else if (CMP_W'(since_t) >= CMP_W'(ping_per_q)) begin
					res.send_status_request = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				vlsp_pkg::PH_IDLE: begin
					if (byte_s1 == vlsp_pkg::CODE_ESC) begin
						phase_n = vlsp_pkg::PH_ESC;
					end else if (byte_s1 == vlsp_pkg::CODE_SEP) begin
						phase_n = vlsp_pkg::PH_SEP;
					end else begin
						res.event_kind = vlsp_pkg::EV_CHAR;
						res.code_first = byte_s1;
					end
				end
				vlsp_pkg::PH_ESC: begin
					if (byte_s1 == vlsp_pkg::CODE_PRO1) begin
						phase_n = vlsp_pkg::PH_P1A;
					end else if (byte_s1 == vlsp_pkg::CODE_PRO2) begin
						phase_n = vlsp_pkg::PH_P2A;
					end else if (byte_s1 == vlsp_pkg::CODE_PRO3) begin
						phase_n = vlsp_pkg::PH_P3A;
					end else begin
						phase_n        = vlsp_pkg::PH_IDLE;
						res.event_kind = vlsp_pkg::EV_ESC;
						res.code_first = byte_s1;
					end
				end
				vlsp_pkg::PH_P1A: begin
					phase_n        = vlsp_pkg::PH_IDLE;
					res.event_kind = vlsp_pkg::EV_PRO1;
					res.code_first = byte_s1;
				end
				vlsp_pkg::PH_P2A: begin
					held1_n = byte_s1;
					phase_n = vlsp_pkg::PH_P2B;
				end
				vlsp_pkg::PH_P2B: begin
					phase_n = vlsp_pkg::PH_IDLE;
					if (held1_q == status_code_q) begin
						pong = 1'b1;
					end else begin
						res.event_kind  = vlsp_pkg::EV_PRO2;
						res.code_first  = held1_q;
						res.code_second = byte_s1;
					end
				end
				vlsp_pkg::PH_P3A: begin
					held1_n = byte_s1;
					phase_n = vlsp_pkg::PH_P3B;
				end
				vlsp_pkg::PH_P3B: begin
					held2_n = byte_s1;
					phase_n = vlsp_pkg::PH_P3C;
				end
				vlsp_pkg::PH_P3C: begin
					phase_n         = vlsp_pkg::PH_IDLE;
					res.event_kind  = vlsp_pkg::EV_PRO3;
					res.code_first  = held1_q;
					res.code_second = held2_q;
					res.code_third  = byte_s1;
				end
				vlsp_pkg::PH_SEP: begin
					phase_n        = vlsp_pkg::PH_IDLE;
					res.event_kind = vlsp_pkg::EV_SEP;
					res.code_first = byte_s1;
				end
				default: phase_n = vlsp_pkg::PH_IDLE;
			endcase

			if (pong) begin
				await_n = 1'b0;
				if (!ready_q) begin
					if (speed_q == vlsp_pkg::SPEED_4800) begin
						ready_n = 1'b1;
					end else begin
						res.send_speed_switch   = 1'b1;
						speed_n                 = vlsp_pkg::SPEED_4800;
						res.send_status_request = 1'b1;
					end
				end
			end

			// events are only reported on a ready link
			if (!ready_n) begin
				res.event_kind  = vlsp_pkg::EV_NONE;
				res.code_first  = '0;
				res.code_second = '0;
				res.code_third  = '0;
			end
		end

		// a status request restarts the reply wait
		if (res.send_status_request) begin
			since_n = '0;
			await_n = 1'b1;
		end else begin
			since_n = since_t;
		end

		res.baud_select = speed_n;
		res.link_ready  = ready_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vlsp_pkg::PH_IDLE;
			held1_q <= '0;
			held2_q <= '0;
			ready_q <= 1'b0;
			speed_q <= vlsp_pkg::SPEED_1200;
			since_q <= '0;
			await_q <= 1'b1;
		end else if (advance) begin
			phase_q <= phase_n;
			held1_q <= held1_n;
			held2_q <= held2_n;
			ready_q <= ready_n;
			speed_q <= speed_n;
			since_q <= since_n;
			await_q <= await_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.event_kind          = res_q.event_kind;
	assign out_ch.code_first          = res_q.code_first;
	assign out_ch.code_second         = res_q.code_second;
	assign out_ch.code_third          = res_q.code_third;
	assign out_ch.send_status_request = res_q.send_status_request;
	assign out_ch.send_speed_switch   = res_q.send_speed_switch;
	assign out_ch.baud_select         = res_q.baud_select;
	assign out_ch.link_ready          = res_q.link_ready;
	assign out_ch.link_restarted      = res_q.link_restarted;

	a_switch_goes_to_4800: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.send_speed_switch |->
			res_q.send_status_request && res_q.baud_select == vlsp_pkg::SPEED_4800
			&& !res_q.link_ready)
		else $error("speed switch without request at 4800");

	a_restart_drops_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.link_restarted |->
			!res_q.link_ready && res_q.send_status_request
			&& res_q.baud_select == vlsp_pkg::SPEED_1200)
		else $error("restart result inconsistent");

	a_ready_at_4800: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.link_ready |-> res_q.baud_select == vlsp_pkg::SPEED_4800)
		else $error("link ready away from 4800");

	a_event_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_kind != vlsp_pkg::EV_NONE |-> res_q.link_ready)
		else $error("event reported on a link that is down");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ROUND_WORDS = 160;
	localparam int IDX_W = vlsp_pkg::CFG_INDEX_W;
	localparam int VAL_W = vlsp_pkg::CFG_DATA_W;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;

	vlsp_in_if  in_ch ();
	vlsp_out_if out_ch ();

	videotex_link_supervisor_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block: configuration and link state
	logic [15:0]                         m_hunt_to;
	logic [15:0]                         m_ready_to;
	logic [15:0]                         m_ping_per;
	logic [7:0]                          m_pong_code;
	logic [3:0]                          m_phase;
	logic [7:0]                          m_held1;
	logic [7:0]                          m_held2;
	logic                                m_up;
	logic [1:0]                          m_speed;
	logic [vlsp_pkg::TIMER_BITS_DEF-1:0] m_since;
	logic                                m_await;
	logic                                f_req;
	logic                                f_sw;
	logic                                f_rst;

	vlsp_pkg::result_t pending_reports[$];
	int      mismatch_cnt;
	int      report_cnt;
	int      words_sent;
	int      cycle_cnt;
	int      stall_left;
	bit      src_idle_on;
	bit      sink_idle_on;

	function automatic int pick_gap(input bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void restart_ping_timer();
		f_req   = 1'b1;
		m_since = '0;
		m_await = 1'b1;
	endfunction

	function automatic vlsp_pkg::result_t predict_link_step(input logic op,
			input logic [7:0] b);
		vlsp_pkg::result_t r;
		r     = '0;
		f_req = 1'b0;
		f_sw  = 1'b0;
		f_rst = 1'b0;
		if (op == vlsp_pkg::OP_TICK) begin
			if (m_since != '1)
				m_since = m_since + 1'b1;
			// supervisor only runs between sequences
			if (m_phase == vlsp_pkg::PH_IDLE) begin
				if (!m_up) begin
					if (!m_await || m_since > m_hunt_to) begin
						case (m_speed)
							vlsp_pkg::SPEED_1200: m_speed = vlsp_pkg::SPEED_4800;
							vlsp_pkg::SPEED_4800: m_speed = vlsp_pkg::SPEED_300;
							default:              m_speed = vlsp_pkg::SPEED_1200;
						endcase
						restart_ping_timer();
					end
				end else if (m_await) begin
					if (m_since > m_ready_to) begin
						m_up    = 1'b0;
						m_speed = vlsp_pkg::SPEED_1200;
						f_rst   = 1'b1;
						restart_ping_timer();
					end
				end else if (m_since >= m_ping_per) begin
					restart_ping_timer();
				end
			end
		end else begin
			case (m_phase)
				vlsp_pkg::PH_IDLE: begin
					if (b == vlsp_pkg::CODE_ESC)
						m_phase = vlsp_pkg::PH_ESC;
					else if (b == vlsp_pkg::CODE_SEP)
						m_phase = vlsp_pkg::PH_SEP;
					else begin
						r.event_kind = vlsp_pkg::EV_CHAR;
						r.code_first = b;
					end
				end
				vlsp_pkg::PH_ESC: begin
					if (b == vlsp_pkg::CODE_PRO1)
						m_phase = vlsp_pkg::PH_P1A;
					else if (b == vlsp_pkg::CODE_PRO2)
						m_phase = vlsp_pkg::PH_P2A;
					else if (b == vlsp_pkg::CODE_PRO3)
						m_phase = vlsp_pkg::PH_P3A;
					else begin
						m_phase      = vlsp_pkg::PH_IDLE;
						r.event_kind = vlsp_pkg::EV_ESC;
						r.code_first = b;
					end
				end
				vlsp_pkg::PH_P1A: begin
					m_phase      = vlsp_pkg::PH_IDLE;
					r.event_kind = vlsp_pkg::EV_PRO1;
					r.code_first = b;
				end
				vlsp_pkg::PH_P2A: begin
					m_held1 = b;
					m_phase = vlsp_pkg::PH_P2B;
				end
				vlsp_pkg::PH_P2B: begin
					m_phase = vlsp_pkg::PH_IDLE;
					if (m_held1 == m_pong_code) begin
						m_await = 1'b0;
						if (!m_up) begin
							if (m_speed == vlsp_pkg::SPEED_4800)
								m_up = 1'b1;
							else begin
								f_sw    = 1'b1;
								m_speed = vlsp_pkg::SPEED_4800;
								restart_ping_timer();
							end
						end
					end else begin
						r.event_kind  = vlsp_pkg::EV_PRO2;
						r.code_first  = m_held1;
						r.code_second = b;
					end
				end
				vlsp_pkg::PH_P3A: begin
					m_held1 = b;
					m_phase = vlsp_pkg::PH_P3B;
				end
				vlsp_pkg::PH_P3B: begin
					m_held2 = b;
					m_phase = vlsp_pkg::PH_P3C;
				end
				vlsp_pkg::PH_P3C: begin
					m_phase       = vlsp_pkg::PH_IDLE;
					r.event_kind  = vlsp_pkg::EV_PRO3;
					r.code_first  = m_held1;
					r.code_second = m_held2;
					r.code_third  = b;
				end
				vlsp_pkg::PH_SEP: begin
					m_phase      = vlsp_pkg::PH_IDLE;
					r.event_kind = vlsp_pkg::EV_SEP;
					r.code_first = b;
				end
				default: m_phase = vlsp_pkg::PH_IDLE;
			endcase
			if (!m_up) begin
				r.event_kind  = vlsp_pkg::EV_NONE;
				r.code_first  = '0;
				r.code_second = '0;
				r.code_third  = '0;
			end
		end
		r.send_status_request = f_req;
		r.send_speed_switch   = f_sw;
		r.baud_select         = m_speed;
		r.link_ready          = m_up;
		r.link_restarted      = f_rst;
		return r;
	endfunction

	function automatic string fmt_report(input vlsp_pkg::result_t r);
		return $sformatf("kind=%0d codes=%h/%h/%h req=%b switch=%b baud=%0d up=%b restart=%b",
			r.event_kind, r.code_first, r.code_second, r.code_third, r.send_status_request,
			r.send_speed_switch, r.baud_select, r.link_ready, r.link_restarted);
	endfunction

	// result side: random stalls on ready
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left   <= pick_gap(sink_idle_on);
		end
	end

	always @(posedge clk) begin : check_result
		vlsp_pkg::result_t got;
		vlsp_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.event_kind, out_ch.code_first, out_ch.code_second, out_ch.code_third,
				out_ch.send_status_request, out_ch.send_speed_switch, out_ch.baud_select,
				out_ch.link_ready, out_ch.link_restarted};
			if (pending_reports.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result word %0d: %s", report_cnt, fmt_report(got));
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("result word %0d mismatch", report_cnt);
						$display("  expected %s", fmt_report(want));
						$display("  actual   %s", fmt_report(got));
					end
				end
			end
			report_cnt++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// valid is only lowered when a gap follows, so back-to-back words keep it high
	task automatic send_word(input logic op, input logic [7:0] b);
		int gap;
		gap = pick_gap(src_idle_on);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.byte_value <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_reports.push_back(predict_link_step(op, b));
		words_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_word(vlsp_pkg::OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_pro2(input logic [7:0] a, input logic [7:0] b);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_PRO2);
		send_word(vlsp_pkg::OP_BYTE, a);
		send_word(vlsp_pkg::OP_BYTE, b);
	endtask

	task automatic send_pong();
		send_pro2(m_pong_code, 8'($urandom_range(0, 255)));
	endtask

	task automatic bring_link_up();
		while (!m_up)
			send_pong();
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			vlsp_pkg::REG_HUNT_TIMEOUT:  m_hunt_to   = val;
			vlsp_pkg::REG_READY_TIMEOUT: m_ready_to  = val;
			vlsp_pkg::REG_PING_PERIOD:   m_ping_per  = val;
			vlsp_pkg::REG_STATUS_CODE:   m_pong_code = val[7:0];
			default: ;
		endcase
	endtask

	// caller makes sure the block is idle; a stray index at the end must be ignored
	task automatic load_config(input logic [15:0] hunt, input logic [15:0] rdy,
			input logic [15:0] ping, input logic [15:0] code);
		write_reg(vlsp_pkg::REG_HUNT_TIMEOUT, hunt);
		write_reg(vlsp_pkg::REG_READY_TIMEOUT, rdy);
		write_reg(vlsp_pkg::REG_PING_PERIOD, ping);
		write_reg(vlsp_pkg::REG_STATUS_CODE, code);
		write_reg(IDX_W'($urandom_range(4, 255)), VAL_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
	endtask

	task automatic test_link_up();
		// link down: nothing reported, pong at 1200 orders the switch
		send_word(vlsp_pkg::OP_BYTE, 8'h41);
		send_word(vlsp_pkg::OP_BYTE, 8'hFF);
		send_pro2(8'h20, 8'h00);
		send_pong();
		send_pong();
	endtask

	task automatic test_events();
		send_word(vlsp_pkg::OP_BYTE, 8'h00);
		send_word(vlsp_pkg::OP_BYTE, 8'hFF);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, 8'hFF);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_SEP);
		send_word(vlsp_pkg::OP_BYTE, 8'h00);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_PRO1);
		send_word(vlsp_pkg::OP_BYTE, 8'hFF);
		send_pro2(8'h00, 8'hFF);
		// ticks in the middle of a three-code reply
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_PRO3);
		send_word(vlsp_pkg::OP_BYTE, 8'h01);
		send_ticks(1);
		send_word(vlsp_pkg::OP_BYTE, 8'h80);
		send_ticks(1);
		send_word(vlsp_pkg::OP_BYTE, 8'hFE);
		send_pong();
	endtask

	task automatic test_timeouts();
		wait_idle();
		load_config(16'd1, 16'd2, 16'd3, 16'hFF71);
		send_ticks(12);
		bring_link_up();
		// leave the link down with a reply outstanding
		while (m_up)
			send_ticks(1);
	endtask

	// maximum timeouts: a long run of ticks must not fire any of them
	task automatic test_long_timeouts();
		wait_idle();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
		send_ticks(300);
		bring_link_up();
		send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
		send_ticks(10);
		send_word(vlsp_pkg::OP_BYTE, 8'h5A);
		send_ticks(3);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	task automatic send_random_sequence();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			send_ticks($urandom_range(1, 8));
		else if (r < 42)
			send_pong();
		else if (r < 55)
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		else if (r < 62) begin
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end else if (r < 69) begin
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_PRO1);
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end else if (r < 77)
			send_pro2(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		else if (r < 87) begin
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_ESC);
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_PRO3);
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0)
				send_ticks($urandom_range(1, 3));
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end else if (r < 93) begin
			send_word(vlsp_pkg::OP_BYTE, vlsp_pkg::CODE_SEP);
			send_word(vlsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			// noise, may leave the parser inside a sequence
			repeat ($urandom_range(1, 4))
				send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random();
		int start;
		for (int round = 0; round < 4; round++) begin
			wait_idle();
			case (round)
				0: load_config(16'd1, 16'd1, 16'd1, 16'h0000);
				1, 2: load_config(16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
					16'($urandom_range(1, 40)), 16'($urandom_range(0, 65535)));
				default: load_config(16'd20, 16'd60, 16'd30, 16'h8071);
			endcase
			src_idle_on  = (round != 2);
			sink_idle_on = (round != 1);
			start = words_sent;
			while (words_sent - start < RANDOM_ROUND_WORDS)
				send_random_sequence();
		end
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.operation  = vlsp_pkg::OP_BYTE;
		in_ch.byte_value = '0;
		out_ch.ready     = 1'b0;
		src_idle_on      = 1'b1;
		sink_idle_on     = 1'b1;
		m_hunt_to        = vlsp_pkg::HUNT_TIMEOUT_RST;
		m_ready_to       = vlsp_pkg::READY_TIMEOUT_RST;
		m_ping_per       = vlsp_pkg::PING_PERIOD_RST;
		m_pong_code      = vlsp_pkg::STATUS_CODE_RST;
		m_phase          = vlsp_pkg::PH_IDLE;
		m_held1          = '0;
		m_held2          = '0;
		m_up             = 1'b0;
		m_speed          = vlsp_pkg::SPEED_1200;
		m_since          = '0;
		m_await          = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_link_up();
		test_events();
		test_timeouts();
		test_long_timeouts();
		test_random();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_reports.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
